FILE: design/ptt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_pkg
// shared constants and types for the page table translate block
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int ENTRIES   = 8;
  localparam int ADDR_BITS = 31;

  // field widths fixed by the item format
  localparam int PageW     = 16;
  localparam int PsizeW    = 17;
  localparam int SlotW     = 3;
  localparam int LaddrW    = 31;
  localparam int PaddrW    = 32;

  // table index and divider widths
  localparam int IdxW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int QuoW      = (ADDR_BITS > PageW) ? ADDR_BITS : PageW + 1;
  localparam int CntW      = $clog2(QuoW + 1);

  // item kinds on the input user bit
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_XLAT = 1'b1;

  // register index, taken from byte address bit 2
  localparam logic REG_PAGE_SIZE = 1'b0;

  typedef struct packed {
    logic [PageW-1:0] lpn;
    logic             vld;
    logic [PageW-1:0] ppn;
  } ptt_entry_t;

  typedef struct packed {
    logic       hit;
    ptt_entry_t entry;
  } ptt_match_t;

  typedef struct packed {
    logic              done;
    logic [QuoW-1:0]   quo;
    logic [PsizeW-1:0] rem;
  } ptt_div_res_t;

endpackage

FILE: design/page_table_translate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_translate
// page table mmu with a configurable, non power of two page size
// ----------------------------------------------------------------------------
// sequence: a load item is written into its slot on acceptance and the block
//   stays ready; a translate item runs the bit-serial divider, the table match
//   and the result phase, then loads the output register, which may wait on
//   out_tready; with a zero page size the divider is skipped and the item faults
// one item at a time: no new item is taken until the result has been loaded
// reset: synchronous active low; page_size returns to 4096, all slots clear
// ----------------------------------------------------------------------------
module page_table_translate (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // entry_index[2:0], entry_logical_page[18:3], entry_valid[19],
  // entry_physical_page[35:20], logical_address[66:36], zero[71:67]
  input  logic [71:0] in_tdata,
  // kind[0]
  input  logic        in_tuser,
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // physical_address[31:0]
  output logic [31:0] out_tdata,
  // page_fault[0]
  output logic        out_tuser,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ptt_pkg::*;

  // sequencer codes
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_MATCH  = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  localparam logic [PsizeW-1:0] PsizeReset = PsizeW'(4096);

  logic [1:0]        state_r, state_nxt;
  logic [PsizeW-1:0] psize_r;
  logic              cfg_wr;

  logic              in_acc;
  logic [SlotW-1:0]  in_slot;
  ptt_entry_t        in_entry;
  logic [LaddrW-1:0] in_laddr;

  ptt_div_res_t      div_res;
  logic              div_start;
  logic [QuoW-1:0]   dividend;

  logic              page_ok;
  ptt_match_t        match;
  logic              fault_r, fault_nxt;
  logic [PageW-1:0]  ppn_r;

  logic              out_free;
  logic              out_load;
  logic              out_tvalid_r;
  logic [PaddrW-1:0] out_addr_r;
  logic              out_fault_r;
  logic [PsizeW+PageW-1:0] product;
  logic [PsizeW+PageW-1:0] phys;

  // ---------------------------------------------------------------------------
  // configuration: single register at byte address 0
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_PAGE_SIZE);
  assign cfg_prdata = (cfg_paddr[2] == REG_PAGE_SIZE) ? 32'(psize_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psize_r <= PsizeReset;
    end else if (cfg_wr) begin
      psize_r <= cfg_pwdata[PsizeW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // input unpacking
  // ---------------------------------------------------------------------------
  assign in_tready    = (state_r == ST_IDLE);
  assign in_acc       = in_tvalid && in_tready;
  assign in_slot      = in_tdata[2:0];
  assign in_entry.lpn = in_tdata[18:3];
  assign in_entry.vld = in_tdata[19];
  assign in_entry.ppn = in_tdata[35:20];
  assign in_laddr     = in_tdata[66:36];

  // only the low ADDR_BITS bits of the address take part
  assign dividend = QuoW'(ADDR_BITS'(in_laddr));

  // a zero page size skips the divider and faults straight away
  assign div_start = in_acc && (in_tuser == KIND_XLAT) && (psize_r != '0);

  ptt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (psize_r),
    .res      (div_res)
  );

  // a page number above the stored width can never match
  assign page_ok = (div_res.quo[QuoW-1:PageW] == '0);

  ptt_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .we       (in_acc && (in_tuser == KIND_LOAD)),
    .slot     (in_slot),
    .wr_entry (in_entry),
    .page_ok  (page_ok),
    .page     (div_res.quo[PageW-1:0]),
    .match    (match)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign out_free = !out_tvalid_r || out_tready;
  assign out_load = (state_r == ST_RESULT) && out_free;

  always_comb begin
    state_nxt = state_r;
    fault_nxt = fault_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == KIND_XLAT)) begin
          if (psize_r == '0) begin
            fault_nxt = 1'b1;
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        // shadowed mapping: first match decides, even when invalid
        fault_nxt = !(match.hit && match.entry.vld);
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fault_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fault_r <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MATCH) begin
      ppn_r <= match.entry.ppn;
    end
  end

  // ---------------------------------------------------------------------------
  // physical address: one multiply and add, then the output register
  // ---------------------------------------------------------------------------
  assign product = (PsizeW+PageW)'(ppn_r) * (PsizeW+PageW)'(psize_r);
  assign phys    = product + (PsizeW+PageW)'(div_res.rem);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_fault_r <= fault_r;
      out_addr_r  <= fault_r ? '0 : phys[PaddrW-1:0];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_fault_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("faulted item carries a nonzero address");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == ST_RESULT)
    else $error("result item raised without the result phase");

endmodule

FILE: design/ptt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ptt_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ptt_pkg::QuoW-1:0]  dividend,
  input  logic [ptt_pkg::PsizeW-1:0] divisor,
  output ptt_pkg::ptt_div_res_t     res
);
  import ptt_pkg::*;

  logic [QuoW-1:0]   quo_r, quo_nxt;
  logic [PsizeW-1:0] rem_r, rem_nxt;
  logic [PsizeW-1:0] dvs_r;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [PsizeW:0]   shifted;
  logic [PsizeW:0]   diff;
  logic              fits;

  assign shifted = {rem_r, quo_r[QuoW-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CntW'(QuoW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[QuoW-2:0], fits};
      rem_nxt = fits ? diff[PsizeW-1:0] : shifted[PsizeW-1:0];
      cnt_nxt = cnt_r - CntW'(1);
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r;

endmodule

FILE: design/ptt_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_table
// page table slots with first-match lookup
// ----------------------------------------------------------------------------
module ptt_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      we,
  input  logic [ptt_pkg::SlotW-1:0] slot,
  input  ptt_pkg::ptt_entry_t       wr_entry,
  input  logic                      page_ok,
  input  logic [ptt_pkg::PageW-1:0] page,
  output ptt_pkg::ptt_match_t       match
);
  import ptt_pkg::*;

  ptt_entry_t       ent_r [ENTRIES];
  logic [IdxW-1:0]  widx;
  logic             in_range;

  assign widx     = IdxW'(slot);
  assign in_range = 32'(slot) < ENTRIES;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        ent_r[i] <= '0;
      end
    end else if (we && in_range) begin
      ent_r[widx] <= wr_entry;
    end
  end

  // lowest matching slot wins
  always_comb begin
    match = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (page_ok && ent_r[i].lpn == page) begin
        match.hit   = 1'b1;
        match.entry = ent_r[i];
      end
    end
  end

endmodule

FILE: bench/page_table_translate_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_translate_test
// self-checking bench for the page table mmu: loads table slots, translates
// addresses under several page sizes and idling patterns, and compares each
// result with a built-in predictor of the table lookup
// ----------------------------------------------------------------------------
module page_table_translate_test;

  import ptt_pkg::*;

  // one expected translation
  typedef struct packed {
    logic [PaddrW-1:0] paddr;
    logic              fault;
  } translation_t;

  // register map
  localparam logic [2:0] PAGE_SIZE_ADDR = {REG_PAGE_SIZE, 2'b00};

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 5;
  // settle time after the last result, with margin over one translate item
  localparam int SETTLE_CYCLES = 40;
  // cycles with no handshake at all before the run is declared hung
  localparam int QUIET_LIMIT  = 2000;
  localparam int REPORT_LIMIT = 20;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  // entry_index[2:0], entry_logical_page[18:3], entry_valid[19],
  // entry_physical_page[35:20], logical_address[66:36], zero[71:67]
  logic [71:0] in_tdata    = '0;
  // kind[0]
  logic        in_tuser    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  // physical_address[31:0]
  logic [31:0] out_tdata;
  // page_fault[0]
  logic        out_tuser;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predictor state: page size register and the translation table
  logic [PsizeW-1:0] page_size_reg;
  ptt_entry_t        table_model [ENTRIES];
  translation_t      pending_translations [$];

  int errors;
  int send_idle_pct;
  int recv_stall_pct;

  page_table_translate u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor: divide by the page size, first matching slot decides
  // ---------------------------------------------------------------------------
  function automatic translation_t translate_address(input logic [LaddrW-1:0] laddr);
    translation_t res;
    logic [63:0]  psize;
    logic [63:0]  quo;
    logic [63:0]  rem;
    logic [63:0]  prod;
    logic         found;
    res.paddr = '0;
    res.fault = 1'b1;
    found     = 1'b0;
    psize     = {47'd0, page_size_reg};
    // zero page size faults everything
    if (psize != 64'd0) begin
      quo = {33'd0, laddr} / psize;
      rem = {33'd0, laddr} % psize;
      // a quotient wider than 16 bits never matches a slot
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found && quo == {48'd0, table_model[i].lpn}) begin
          found = 1'b1;
          // an invalid first match shadows any later valid one
          if (table_model[i].vld) begin
            prod      = {48'd0, table_model[i].ppn} * psize + rem;
            res.paddr = prod[31:0];
            res.fault = 1'b0;
          end
        end
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: one item per call, valid stays up so back-to-back items
  // never lower and raise it within one step
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic kind, input logic [71:0] data);
    ptt_entry_t slot_entry;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // item accepted at this edge, update the predictor in order
    if (kind == KIND_LOAD) begin
      if (data[2:0] < ENTRIES) begin
        slot_entry.lpn = data[18:3];
        slot_entry.vld = data[19];
        slot_entry.ppn = data[35:20];
        table_model[data[2:0]] = slot_entry;
      end
    end else begin
      pending_translations.push_back(translate_address(data[66:36]));
    end
  endtask

  // load item, the address field carries noise
  task automatic send_load(input logic [SlotW-1:0] slot, input logic [PageW-1:0] lpn,
                           input logic vld, input logic [PageW-1:0] ppn);
    logic [LaddrW-1:0] noise;
    noise = LaddrW'($urandom);
    send_item(KIND_LOAD, {5'd0, noise, ppn, vld, lpn, slot});
  endtask

  // translate item, the entry fields carry noise
  task automatic send_translate(input logic [LaddrW-1:0] laddr);
    logic [35:0] noise;
    noise = 36'({$urandom, $urandom});
    send_item(KIND_XLAT, {5'd0, laddr, noise});
  endtask

  // stop sending and wait until every translation is back and the block settles
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_translations.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // config side: write page size while idle, then read it back
  // ---------------------------------------------------------------------------
  task automatic write_page_size(input logic [PsizeW-1:0] value);
    drain_results();
    // setup phase
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= PAGE_SIZE_ADDR;
    cfg_pwdata  <= {15'd0, value};
    @(posedge clk);
    // access phase, register written at the edge with pready high
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    page_size_reg = value;
    // read back
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== {15'd0, value}) begin
      if (errors < REPORT_LIMIT)
        $display("%0t page_size readback: expected %h actual %h",
                 $time, {15'd0, value}, cfg_prdata);
      errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls and the field-by-field check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_result
    translation_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_translations.size() == 0) begin
        if (errors < REPORT_LIMIT)
          $display("%0t unexpected result: expected none actual addr %h fault %b",
                   $time, out_tdata, out_tuser);
        errors++;
      end else begin
        want = pending_translations.pop_front();
        if (out_tdata !== want.paddr) begin
          if (errors < REPORT_LIMIT)
            $display("%0t physical_address: expected %h actual %h",
                     $time, want.paddr, out_tdata);
          errors++;
        end
        if (out_tuser !== want.fault) begin
          if (errors < REPORT_LIMIT)
            $display("%0t page_fault: expected %b actual %b",
                     $time, want.fault, out_tuser);
          errors++;
        end
      end
    end
  end

  // hang detection: any handshake restarts the count
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // cleared table: every slot is logical page 0, invalid
  task automatic test_reset_state();
    // address zero goes through the table like any other
    send_translate('0);
    // quotient far above 16 bits
    send_translate({LaddrW{1'b1}});
  endtask

  task automatic test_table_mapping();
    send_load(3'd0, 16'd5, 1'b1, 16'hFFFF);
    send_load(3'd7, 16'hFFFF, 1'b1, 16'h0000);
    send_translate(31'(5 * 4096));
    send_translate(31'(5 * 4096 + 4095));
    send_translate(31'(65535 * 4096 + 123));
  endtask

  task automatic test_shadowed_entry();
    // invalid slot 2 hides valid slot 3 for the same page
    send_load(3'd2, 16'd9, 1'b0, 16'd1);
    send_load(3'd3, 16'd9, 1'b1, 16'd2);
    send_translate(31'(9 * 4096 + 7));
    // move slot 2 away, slot 3 now decides
    send_load(3'd2, 16'd10, 1'b1, 16'd3);
    send_translate(31'(9 * 4096 + 7));
    // sender holds off until every result is back
    drain_results();
  endtask

  task automatic test_page_size_extremes();
    write_page_size(17'd1);
    send_translate(31'd5);
    send_translate(31'd65535);
    // largest in-range page, top physical page gives all ones
    write_page_size(17'd65536);
    send_translate(31'(5 * 65536 + 65535));
    // page size above range, physical address wraps to 32 bits
    write_page_size(17'd131071);
    send_translate(31'(5 * 131071 + 3));
    // zero page size faults every translate
    write_page_size(17'd0);
    send_translate('0);
    send_translate(31'd5);
  endtask

  // ---------------------------------------------------------------------------
  // random traffic: mostly translates aimed at pages held in the table,
  // loads from a small page pool so duplicates and shadowing occur
  // ---------------------------------------------------------------------------
  task automatic run_random_items(input int count);
    int unsigned pick;
    int unsigned lpn;
    int unsigned offset;
    logic [63:0] addr;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        pick = $urandom_range(3);
        if (pick < 2)
          lpn = $urandom_range(15);
        else if (pick == 2)
          lpn = $urandom_range(65535);
        else
          lpn = 65535 - $urandom_range(15);
        send_load(SlotW'($urandom_range(7)), lpn[15:0], $urandom_range(99) < 75,
                  PageW'($urandom_range(65535)));
      end else if (pick < 85) begin
        // hit a stored page at a random offset
        lpn    = 32'(table_model[IdxW'($urandom_range(ENTRIES - 1))].lpn);
        offset = (page_size_reg == '0) ? 0 : $urandom_range(page_size_reg - 1);
        addr   = 64'(lpn) * 64'(page_size_reg) + 64'(offset);
        if (addr > 64'h7FFF_FFFF)
          addr = 64'($urandom);
        send_translate(addr[LaddrW-1:0]);
      end else if (pick < 93) begin
        send_translate(LaddrW'($urandom));
      end else begin
        send_translate(LaddrW'($urandom_range(1 << 20)));
      end
    end
  endtask

  task automatic test_random_traffic();
    set_idling(0, 0);
    write_page_size(17'd4096);
    run_random_items(250);
    set_idling(80, 0);
    write_page_size(PsizeW'($urandom_range(65535, 2)));
    run_random_items(250);
    set_idling(0, 80);
    write_page_size(17'd1);
    run_random_items(200);
    set_idling(15, 15);
    write_page_size(17'd65536);
    run_random_items(250);
    set_idling(0, 0);
    write_page_size(PsizeW'($urandom_range(131071, 65537)));
    run_random_items(150);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    errors         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    page_size_reg  = 17'd4096;
    for (int i = 0; i < ENTRIES; i++) table_model[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_table_mapping();
    test_shadowed_entry();
    test_page_size_extremes();
    test_random_traffic();

    drain_results();
    if (errors == 0 && pending_translations.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
